// ----- design/ttsc_pkg.sv -----
package ttsc_pkg;

    // widths fixed by the item and register formats
    localparam int POS_W       = 12;
    localparam int TIME_W      = 32;
    localparam int TRAVEL_W    = 12;
    localparam int DUR_W       = 16;
    localparam int SQ_W        = 2 * TRAVEL_W;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 16;

    localparam int COORD_BITS_DEF = 12;

    // register reset values, squares kept alongside the plain values
    localparam logic [TRAVEL_W-1:0] SWIPE_MIN_TRAVEL_RST   = TRAVEL_W'(40);
    localparam logic [DUR_W-1:0]    SWIPE_MAX_DURATION_RST = DUR_W'(300);
    localparam logic [TRAVEL_W-1:0] TAP_MAX_TRAVEL_RST     = TRAVEL_W'(15);
    localparam logic [DUR_W-1:0]    TAP_MAX_DURATION_RST   = DUR_W'(250);
    localparam logic [SQ_W-1:0]     SWIPE_MIN_SQ_RST       = SQ_W'(40 * 40);
    localparam logic [SQ_W-1:0]     TAP_MAX_SQ_RST         = SQ_W'(15 * 15);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SWIPE_MIN_TRAVEL   = 8'd0,
        CFG_SWIPE_MAX_DURATION = 8'd1,
        CFG_TAP_MAX_TRAVEL     = 8'd2,
        CFG_TAP_MAX_DURATION   = 8'd3
    } ttsc_cfg_idx_t;

    typedef enum logic {
        FUNC_SAMPLE = 1'b0,
        FUNC_REARM  = 1'b1
    } ttsc_func_t;

    typedef enum logic {
        GESTURE_TAP   = 1'b0,
        GESTURE_SWIPE = 1'b1
    } ttsc_gesture_t;

    typedef struct packed {
        ttsc_func_t        func;
        logic              pressed;
        logic [POS_W-1:0]  pos_x;
        logic [POS_W-1:0]  pos_y;
        logic [TIME_W-1:0] now_ms;
    } ttsc_item_t;

    typedef struct packed {
        ttsc_gesture_t     gesture;
        logic [TIME_W-1:0] stamp_ms;
    } ttsc_result_t;

    // thresholds as the classifier uses them
    typedef struct packed {
        logic [SQ_W-1:0]  swipe_min_sq;
        logic [DUR_W-1:0] swipe_max_dur;
        logic [SQ_W-1:0]  tap_max_sq;
        logic [DUR_W-1:0] tap_max_dur;
    } ttsc_cfg_t;

endpackage

// ----- design/touch_tap_swipe_classifier_core.sv -----
// an accepted beat is held in the input register until the output register has room; its result, if any,
// is loaded into the output register as the beat leaves, and m_valid is driven from the output register
// throughput: one beat per cycle while the output is not stalled, set by the state update in the tracker
// reset (aresetn low, synchronous): both registers empty, finger up, gesture spent,
// thresholds back to 40 / 300 ms swipe and 15 / 250 ms tap
module touch_tap_swipe_classifier_core #(
    parameter int COORD_BITS = ttsc_pkg::COORD_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,

    // sample channel
    input  logic                               s_valid,
    output logic                               s_ready,
    input  ttsc_pkg::ttsc_item_t               s_data,

    // gesture channel
    output logic                               m_valid,
    input  logic                               m_ready,
    output ttsc_pkg::ttsc_result_t             m_data,

    // register write channel
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ttsc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ttsc_pkg::CFG_DATA_W-1:0]    cfg_data
);

    ttsc_pkg::ttsc_cfg_t    cfg;

    // input register
    logic                   in_valid_reg, in_valid_next;
    ttsc_pkg::ttsc_item_t   in_item_reg;
    logic                   in_load;

    // output register
    logic                   out_valid_reg, out_valid_next;
    ttsc_pkg::ttsc_result_t out_data_reg;

    // tracker side
    logic                   advance;
    logic                   emit;
    ttsc_pkg::ttsc_result_t result;

    // register writes are always accepted and take effect in the next cycle
    assign cfg_ready = 1'b1;

    ttsc_cfg_regs u_cfg_regs (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // the held beat moves on whenever the output register has room for a result
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign in_load = s_valid && s_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (in_load) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    ttsc_tracker #(
        .COORD_BITS (COORD_BITS)
    ) u_tracker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (advance),
        .item       (in_item_reg),
        .cfg        (cfg),
        .emit       (emit),
        .result     (result)
    );

    // result register, refilled in the same cycle it is drained
    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance && emit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (in_load) begin
            in_item_reg <= s_data;
        end
        if (advance && emit) begin
            out_data_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // a produced result must show up on the output next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && emit |=> m_valid)
        else $error("result dropped");

    // a stalled output with a beat waiting must stall the input
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && m_valid && !m_ready |-> !s_ready)
        else $error("input taken while pipeline blocked");

    // new results only come from a beat leaving the input register
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(advance))
        else $error("result without a beat");

endmodule

// ----- design/ttsc_cfg_regs.sv -----
module ttsc_cfg_regs (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                wr_en,
    input  logic [ttsc_pkg::CFG_IDX_W-1:0]      wr_index,
    input  logic [ttsc_pkg::CFG_DATA_W-1:0]     wr_data,
    output ttsc_pkg::ttsc_cfg_t                 cfg
);

    logic [ttsc_pkg::TRAVEL_W-1:0] wr_travel;
    logic [ttsc_pkg::SQ_W-1:0]     wr_travel_sq;
    logic [ttsc_pkg::DUR_W-1:0]    wr_dur;

    ttsc_pkg::ttsc_cfg_t cfg_reg;
    ttsc_pkg::ttsc_cfg_t cfg_next;

    assign wr_travel    = wr_data[ttsc_pkg::TRAVEL_W-1:0];
    assign wr_dur       = wr_data[ttsc_pkg::DUR_W-1:0];
    // square the travel once at write time
    assign wr_travel_sq = ttsc_pkg::SQ_W'(wr_travel) * ttsc_pkg::SQ_W'(wr_travel);

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (wr_index)
                ttsc_pkg::CFG_SWIPE_MIN_TRAVEL:   cfg_next.swipe_min_sq  = wr_travel_sq;
                ttsc_pkg::CFG_SWIPE_MAX_DURATION: cfg_next.swipe_max_dur = wr_dur;
                ttsc_pkg::CFG_TAP_MAX_TRAVEL:     cfg_next.tap_max_sq    = wr_travel_sq;
                ttsc_pkg::CFG_TAP_MAX_DURATION:   cfg_next.tap_max_dur   = wr_dur;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.swipe_min_sq  <= ttsc_pkg::SWIPE_MIN_SQ_RST;
            cfg_reg.swipe_max_dur <= ttsc_pkg::SWIPE_MAX_DURATION_RST;
            cfg_reg.tap_max_sq    <= ttsc_pkg::TAP_MAX_SQ_RST;
            cfg_reg.tap_max_dur   <= ttsc_pkg::TAP_MAX_DURATION_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- design/ttsc_dist_sq.sv -----
module ttsc_dist_sq #(
    parameter int COORD_BITS = ttsc_pkg::COORD_BITS_DEF
) (
    input  logic [COORD_BITS-1:0]   ax,
    input  logic [COORD_BITS-1:0]   ay,
    input  logic [COORD_BITS-1:0]   bx,
    input  logic [COORD_BITS-1:0]   by,
    output logic [2*COORD_BITS:0]   d2
);

    localparam int PROD_W = 2 * COORD_BITS;

    logic [COORD_BITS-1:0] dx;
    logic [COORD_BITS-1:0] dy;
    logic [PROD_W-1:0]     dx_sq;
    logic [PROD_W-1:0]     dy_sq;

    // absolute differences
    assign dx = (ax >= bx) ? (ax - bx) : (bx - ax);
    assign dy = (ay >= by) ? (ay - by) : (by - ay);

    assign dx_sq = PROD_W'(dx) * PROD_W'(dx);
    assign dy_sq = PROD_W'(dy) * PROD_W'(dy);

    assign d2 = (PROD_W + 1)'(dx_sq) + (PROD_W + 1)'(dy_sq);

endmodule

// ----- design/ttsc_tracker.sv -----
module ttsc_tracker #(
    parameter int COORD_BITS = ttsc_pkg::COORD_BITS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     item_valid,
    input  ttsc_pkg::ttsc_item_t     item,
    input  ttsc_pkg::ttsc_cfg_t      cfg,
    output logic                     emit,
    output ttsc_pkg::ttsc_result_t   result
);

    localparam int D2_W  = 2 * COORD_BITS + 1;
    localparam int CMP_W = (D2_W > ttsc_pkg::SQ_W) ? D2_W : ttsc_pkg::SQ_W;

    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [COORD_BITS-1:0] px;
    logic [COORD_BITS-1:0] py;
    logic [D2_W-1:0]       d2;
    logic [CMP_W-1:0]      d2_ext;
    logic [ttsc_pkg::TIME_W-1:0] duration;
    logic                  swipe_far;
    logic                  swipe_quick;
    logic                  tap_near;
    logic                  tap_quick;

    logic                  finger_down_reg, finger_down_next;
    logic                  spent_reg, spent_next;
    logic [COORD_BITS-1:0] start_x_reg, start_x_next;
    logic [COORD_BITS-1:0] start_y_reg, start_y_next;
    logic [COORD_BITS-1:0] last_x_reg, last_x_next;
    logic [COORD_BITS-1:0] last_y_reg, last_y_next;
    logic [ttsc_pkg::TIME_W-1:0] start_time_reg, start_time_next;

    assign x = COORD_BITS'(item.pos_x);
    assign y = COORD_BITS'(item.pos_y);

    // a held finger measures the new point, a lift measures the last one
    assign px = item.pressed ? x : last_x_reg;
    assign py = item.pressed ? y : last_y_reg;

    ttsc_dist_sq #(
        .COORD_BITS (COORD_BITS)
    ) u_dist_sq (
        .ax (px),
        .ay (py),
        .bx (start_x_reg),
        .by (start_y_reg),
        .d2 (d2)
    );

    assign d2_ext      = CMP_W'(d2);
    assign duration    = item.now_ms - start_time_reg;
    assign swipe_far   = d2_ext >= CMP_W'(cfg.swipe_min_sq);
    assign swipe_quick = duration <= ttsc_pkg::TIME_W'(cfg.swipe_max_dur);
    assign tap_near    = d2_ext <= CMP_W'(cfg.tap_max_sq);
    assign tap_quick   = duration <= ttsc_pkg::TIME_W'(cfg.tap_max_dur);

    always_comb begin
        finger_down_next = finger_down_reg;
        spent_next       = spent_reg;
        start_x_next     = start_x_reg;
        start_y_next     = start_y_reg;
        last_x_next      = last_x_reg;
        last_y_next      = last_y_reg;
        start_time_next  = start_time_reg;
        emit             = 1'b0;
        result.gesture   = ttsc_pkg::GESTURE_TAP;
        result.stamp_ms  = item.now_ms;
        if (item_valid) begin
            if (item.func == ttsc_pkg::FUNC_REARM) begin
                spent_next = 1'b1;
            end else if (item.pressed) begin
                last_x_next = x;
                last_y_next = y;
                if (!finger_down_reg) begin
                    // touch-down arms a new gesture
                    finger_down_next = 1'b1;
                    spent_next       = 1'b0;
                    start_x_next     = x;
                    start_y_next     = y;
                    start_time_next  = item.now_ms;
                end else if (!spent_reg && swipe_far) begin
                    // far enough: swipe if quick, drag otherwise
                    spent_next = 1'b1;
                    if (swipe_quick) begin
                        emit           = 1'b1;
                        result.gesture = ttsc_pkg::GESTURE_SWIPE;
                    end
                end
            end else if (finger_down_reg) begin
                finger_down_next = 1'b0;
                if (!spent_reg && tap_near && tap_quick) begin
                    emit           = 1'b1;
                    result.gesture = ttsc_pkg::GESTURE_TAP;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            finger_down_reg <= 1'b0;
            spent_reg       <= 1'b1;
            start_x_reg     <= '0;
            start_y_reg     <= '0;
            last_x_reg      <= '0;
            last_y_reg      <= '0;
            start_time_reg  <= '0;
        end else begin
            finger_down_reg <= finger_down_next;
            spent_reg       <= spent_next;
            start_x_reg     <= start_x_next;
            start_y_reg     <= start_y_next;
            last_x_reg      <= last_x_next;
            last_y_reg      <= last_y_next;
            start_time_reg  <= start_time_next;
        end
    end

    // a swipe always spends the gesture
    assert property (@(posedge aclk) disable iff (!aresetn)
        emit && result.gesture == ttsc_pkg::GESTURE_SWIPE |=> spent_reg)
        else $error("swipe left gesture armed");

    // a tap only comes with the lift
    assert property (@(posedge aclk) disable iff (!aresetn)
        emit && result.gesture == ttsc_pkg::GESTURE_TAP |=> !finger_down_reg)
        else $error("tap without lift");

endmodule
